>>> src/mpq_pkg.sv
// Shared types and constants for the max priority queue.
// No dependencies; compiled first.
package mpq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_BITS_DEF = 16;
	localparam int TAG_BITS_DEF = 8;
	localparam int STATUS_BITS  = 2;

	// Result status codes
	typedef enum logic [STATUS_BITS-1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} mpq_status_t;

	// Request opcode (req_type field)
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
	} mpq_ctl_t;

endpackage

>>> src/mpq_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on mpq_pkg for default widths and the status type.
interface mpq_req_if
	import mpq_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [KEY_BITS-1:0] new_key;
	logic [TAG_BITS-1:0] new_tag;

	modport source (output valid, req_type, new_key, new_tag, input ready);
	modport sink   (input valid, req_type, new_key, new_tag, output ready);
endinterface

interface mpq_rsp_if
	import mpq_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF,
	parameter int CNT_BITS = $clog2(CAPACITY_DEF + 1)
);
	logic                valid;
	logic                ready;
	mpq_status_t         status;
	logic [KEY_BITS-1:0] out_key;
	logic [TAG_BITS-1:0] out_tag;
	logic [CNT_BITS-1:0] fill_level;

	modport source (output valid, status, out_key, out_tag, fill_level, input ready);
	modport sink   (input valid, status, out_key, out_tag, fill_level, output ready);
endinterface

>>> src/max_priority_queue_unit.sv
// Max priority queue: entries kept sorted by key (ties in push order) in a chain of cells.
// Result: registered in the cycle after the request beat is accepted.
// Throughput: one request per cycle while the result side is ready; every cell updates in parallel from its neighbors.
// Reset: arst_n clears the fill count and the result valid; cell contents stay unset
// and are never read before a push writes them.
// Depends on mpq_pkg, mpq_ifs (channel interfaces) and mpq_cell.
module max_priority_queue_unit
	import mpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mpq_req_if.sink   req,
	mpq_rsp_if.source rsp
);

	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	logic [CNT_BITS-1:0] count_q;
	logic                rsp_valid_q;
	mpq_status_t         rsp_status_q;
	logic [KEY_BITS-1:0] rsp_key_q;
	logic [TAG_BITS-1:0] rsp_tag_q;
	logic [CNT_BITS-1:0] rsp_fill_q;

	logic                req_fire;
	logic                full;
	logic                empty;
	mpq_ctl_t            ctl;
	mpq_status_t         status_d;
	logic [CNT_BITS-1:0] count_d;

	logic [KEY_BITS-1:0] cell_key  [CAPACITY];
	logic [TAG_BITS-1:0] cell_tag  [CAPACITY];
	logic                cell_keep [CAPACITY];
	logic                cell_occ  [CAPACITY];

	// Accept while the result register is empty or being drained
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;

	assign full  = (count_q == CNT_BITS'(CAPACITY));
	assign empty = (count_q == '0);

	// Decode the request into a chain command, status and next count
	always_comb begin
		ctl      = '0;
		status_d = ST_EMPTY;
		count_d  = count_q;
		unique case (req.req_type)
			REQ_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_PUSHED;
					ctl.push = req_fire;
					count_d  = count_q + CNT_BITS'(1);
				end
			end
			REQ_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					status_d = ST_POPPED;
					ctl.pop  = req_fire;
					count_d  = count_q - CNT_BITS'(1);
				end
			end
			default: ;
		endcase
	end

	// Cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                prev_keep;
		logic [KEY_BITS-1:0] left_key;
		logic [TAG_BITS-1:0] left_tag;
		logic [KEY_BITS-1:0] right_key;
		logic [TAG_BITS-1:0] right_tag;

		assign cell_occ[i] = (count_q > CNT_BITS'(i));

		if (i == 0) begin : g_head
			assign prev_keep = 1'b1;
			assign left_key  = req.new_key;
			assign left_tag  = req.new_tag;
		end else begin : g_body
			assign prev_keep = cell_keep[i-1];
			assign left_key  = cell_key[i-1];
			assign left_tag  = cell_tag[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_key = cell_key[i];
			assign right_tag = cell_tag[i];
		end else begin : g_mid
			assign right_key = cell_key[i+1];
			assign right_tag = cell_tag[i+1];
		end

		mpq_cell #(
			.KEY_BITS (KEY_BITS),
			.TAG_BITS (TAG_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (cell_occ[i]),
			.new_key   (req.new_key),
			.new_tag   (req.new_tag),
			.prev_keep (prev_keep),
			.left_key  (left_key),
			.left_tag  (left_tag),
			.right_key (right_key),
			.right_tag (right_tag),
			.keep      (cell_keep[i]),
			.key_q     (cell_key[i]),
			.tag_q     (cell_tag[i])
		);
	end

	// Fill count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				count_q <= count_d;
			end
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result beat; head of chain is the entry being removed
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_status_q <= status_d;
			rsp_fill_q   <= count_d;
			if (status_d == ST_POPPED) begin
				rsp_key_q <= cell_key[0];
				rsp_tag_q <= cell_tag[0];
			end else begin
				rsp_key_q <= '0;
				rsp_tag_q <= '0;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.out_key    = rsp_key_q;
	assign rsp.out_tag    = rsp_tag_q;
	assign rsp.fill_level = rsp_fill_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(CAPACITY))
		else $error("fill count above capacity");

	a_refused_stable: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && ((req.req_type == REQ_PUSH && full) || (req.req_type == REQ_POP && empty))
		|=> $stable(count_q))
		else $error("refused request changed the fill count");

	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req.req_type == REQ_POP && !empty
		|=> rsp_key_q == $past(cell_key[0]) && rsp_status_q == ST_POPPED)
		else $error("pop did not return the head entry");

	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_BITS'(2) |-> cell_key[0] >= cell_key[1])
		else $error("chain head out of key order");
`endif

endmodule

>>> src/mpq_cell.sv
// One cell of the sorted queue chain: holds one key/tag entry.
// Depends on mpq_pkg for the command struct.
module mpq_cell
	import mpq_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic                clk,
	input  mpq_ctl_t            ctl,
	input  logic                occ,
	input  logic [KEY_BITS-1:0] new_key,
	input  logic [TAG_BITS-1:0] new_tag,
	input  logic                prev_keep,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic [TAG_BITS-1:0] left_tag,
	input  logic [KEY_BITS-1:0] right_key,
	input  logic [TAG_BITS-1:0] right_tag,
	output logic                keep,
	output logic [KEY_BITS-1:0] key_q,
	output logic [TAG_BITS-1:0] tag_q
);

	// Stay in place on push when this entry ranks ahead of the new one;
	// equal keys stay ahead so older entries leave first.
	assign keep = occ && (key_q >= new_key);

	// Pop: take right neighbor. Push: hold, insert new, or take left neighbor.
	always_ff @(posedge clk) begin
		priority if (ctl.pop) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end else if (ctl.push && !keep) begin
			if (prev_keep) begin
				key_q <= new_key;
				tag_q <= new_tag;
			end else begin
				key_q <= left_key;
				tag_q <= left_tag;
			end
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for max_priority_queue_unit: directed and random push/pop beats with idling.
// Depends on mpq_pkg, the channel interfaces in mpq_ifs and the RTL of the queue.
module tb
	import mpq_pkg::*;
();

	localparam int KW = KEY_BITS_DEF;
	localparam int TW = TAG_BITS_DEF;
	localparam int CW = $clog2(CAPACITY_DEF + 1);
	localparam int RANDOM_ITEMS = 800;

	typedef struct {
		mpq_status_t   status;
		logic [KW-1:0] key;
		logic [TW-1:0] tag;
		logic [CW-1:0] fill;
	} mpq_result_t;

	// Mirror of the queue contents plus the results still owed by the block
	class mpq_scoreboard;
		logic [KW-1:0] held_keys[$];
		logic [TW-1:0] held_tags[$];
		mpq_result_t   due_results[$];
		int            errors = 0;

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function int pending();
			return due_results.size();
		endfunction

		// Apply one accepted request beat to the mirror and queue its result
		function void note_request(logic op, logic [KW-1:0] k, logic [TW-1:0] t);
			mpq_result_t r;
			int best;
			r.key = '0;
			r.tag = '0;
			if (op == REQ_PUSH) begin
				if (held_keys.size() >= CAPACITY_DEF) begin
					r.status = ST_FULL;
				end else begin
					held_keys.insert(held_keys.size(), k);
					held_tags.insert(held_tags.size(), t);
					r.status = ST_PUSHED;
				end
			end else if (held_keys.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				// strict compare keeps the earliest entry among equal keys
				best = 0;
				for (int i = 1; i < held_keys.size(); i++) begin
					if (held_keys[i] > held_keys[best])
						best = i;
				end
				r.key = held_keys[best];
				r.tag = held_tags[best];
				held_keys.delete(best);
				held_tags.delete(best);
				r.status = ST_POPPED;
			end
			r.fill = CW'(held_keys.size());
			due_results.insert(due_results.size(), r);
		endfunction

		// Compare one result beat with the oldest owed result
		task check_result(mpq_status_t st, logic [KW-1:0] k, logic [TW-1:0] t,
				logic [CW-1:0] f);
			mpq_result_t r;
			if (due_results.size() == 0) begin
				report($sformatf("result beat with nothing owed (status %0d)", st));
			end else begin
				r = due_results.pop_front();
				if (st !== r.status)
					report($sformatf("status %0d, want %0d", st, r.status));
				if (k !== r.key)
					report($sformatf("out_key %h, want %h", k, r.key));
				if (t !== r.tag)
					report($sformatf("out_tag %h, want %h", t, r.tag));
				if (f !== r.fill)
					report($sformatf("fill_level %0d, want %0d", f, r.fill));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int   push_pct;

	mpq_req_if req_ch ();
	mpq_rsp_if rsp_ch ();

	mpq_scoreboard sb = new();

	max_priority_queue_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function bit take_gap();
		return !steady && ($urandom_range(0, 99) < 17);
	endfunction

	// Keys lean toward extremes and a narrow band so ties are common
	function logic [KW-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return KW'($urandom_range(0, 3));
			5: return KW'({KW{1'b1}} - $urandom_range(0, 3));
			default: return KW'($urandom);
		endcase
	endfunction

	// Stall the result side at random
	always @(posedge clk) begin
		rsp_ch.ready <= !take_gap();
	end

	// Record accepted requests first, then check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.req_type, req_ch.new_key, req_ch.new_tag);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.status, rsp_ch.out_key, rsp_ch.out_tag,
					rsp_ch.fill_level);
		end
	end

	// Present one request beat and hold it until accepted; valid stays high on return
	task send_req(logic op, logic [KW-1:0] k, logic [TW-1:0] t);
		while (take_gap()) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.new_key  <= k;
		req_ch.new_tag  <= t;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Drop valid and hold off until every owed result has come back
	task settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task send_random();
		if ($urandom_range(0, 99) < push_pct)
			send_req(REQ_PUSH, pick_key(), TW'($urandom));
		else
			send_req(REQ_POP, KW'($urandom), TW'($urandom));
	endtask

	initial begin
		arst_n          <= 1'b0;
		steady          = 1'b0;
		push_pct        = 50;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_PUSH;
		req_ch.new_key  <= '0;
		req_ch.new_tag  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pop when empty, extremes, ties, fill to full, push when full
		send_req(REQ_POP, '1, '1);
		send_req(REQ_PUSH, '0, '0);
		send_req(REQ_PUSH, '1, '1);
		send_req(REQ_PUSH, KW'(5), TW'(8'h01));
		send_req(REQ_PUSH, KW'(5), TW'(8'h02));
		send_req(REQ_PUSH, '1, TW'(8'h10));
		send_req(REQ_PUSH, '0, TW'(8'h11));
		for (int i = 0; i < CAPACITY_DEF - 6; i++)
			send_req(REQ_PUSH, pick_key(), TW'($urandom));
		send_req(REQ_PUSH, KW'(16'h1234), TW'(8'h56));
		settle();
		for (int i = 0; i < 5; i++)
			send_req(REQ_POP, KW'($urandom), TW'($urandom));

		// Random: phases of push bias walk the fill level between empty and full
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			steady = (n >= 320 && n < 480);
			if (n % 100 == 99)
				settle();
			send_random();
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Abort a hung run
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
src/mpq_pkg.sv
src/mpq_ifs.sv
src/mpq_cell.sv
src/max_priority_queue_unit.sv
tb/tb.sv
